@@ design/odqd_pkg.sv @@
// ----------------------------------------------------------------------------
// odqd_pkg
// Shared types, constants and the 4x transition table for the octal
// quadrature detent decoder.
// ----------------------------------------------------------------------------
package odqd_pkg;

  localparam int CH_W    = 3;   // channel index width
  localparam int DELTA_W = 8;   // detent count width
  localparam int ACC_W   = 4;   // step accumulator width
  localparam int DET_W   = 3;   // detents register width
  localparam int DIR_W   = 8;   // direction mask width

  // register indexes, taken from paddr[2]
  localparam logic REG_DETENTS   = 1'b0;
  localparam logic REG_DIRECTION = 1'b1;

  localparam logic [DET_W-1:0] DETENTS_RESET = 3'd2;
  localparam logic [DET_W-1:0] DETENTS_MIN   = 3'd1;
  localparam logic [DET_W-1:0] DETENTS_MAX   = 3'd4;

  typedef enum logic [1:0] {
    CMD_COUNT = 2'd0,
    CMD_SEED  = 2'd1,
    CMD_READ  = 2'd2
  } cmd_t;

  typedef struct packed {
    logic             count_en;
    logic             seed_en;
    logic [DET_W-1:0] detents;   // effective, 1..4
  } lane_ctrl_t;

  // channel in the low bits, matching the out_tdata layout
  typedef struct packed {
    logic [DELTA_W-1:0] delta;
    logic [CH_W-1:0]    channel;
  } result_t;

  // index = {previous AB, current AB}
  function automatic logic signed [1:0] step_of(input logic [3:0] idx);
    logic signed [1:0] s;
    case (idx)
      4'd1, 4'd7, 4'd8, 4'd14: s = -2'sd1;
      4'd2, 4'd4, 4'd11, 4'd13: s = 2'sd1;
      default: s = 2'sd0;
    endcase
    return s;
  endfunction

endpackage

@@ design/octal_quadrature_detent_decoder.sv @@
// ----------------------------------------------------------------------------
// octal_quadrature_detent_decoder
// Eight-lane quadrature decoder with detent counting and read-and-clear.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream (in_*): one transfer per command. in_tuser carries the
//   command (count, seed, read); in_tdata carries the pin snapshot and the
//   channel to read. Count and seed give no result; read gives one.
//   Output stream (out_*): one transfer per read, carrying the channel and
//   its signed detent delta; the channel's count is cleared on the read.
//   Config (cfg_*): APB. 0x0 detents_per_step, 0x4 direction_mask. Write
//   only while the stream is idle.
// Timing:
//   All encoder lanes update together in the cycle a transfer is accepted,
//   so one command is taken every cycle while in_tready is high. A read
//   result is registered in the output buffer and shown on out_* once the
//   output register is free; otherwise it waits in the skid stage.
// Reset / stall:
//   rst_n (synchronous) clears pairs, accumulators, counts and the output
//   buffer and loads detents_per_step = 2, direction_mask = 0.
//   When out_tready is low, one read result sits in the output register and
//   a second in the skid stage; in_tready drops only while the skid is full.
// ----------------------------------------------------------------------------
module octal_quadrature_detent_decoder #(
  parameter int ENCODER_COUNT = 8   // 1..8
) (
  input  logic        clk,
  input  logic        rst_n,
  // input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // [15:0] snapshot, [18:16] channel, [23:19] zero
  input  logic [1:0]  in_tuser,   // [1:0] command
  // result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [2:0] read_channel, [10:3] detent_delta, [15:11] zero
  // configuration
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  // configuration registers
  logic [odqd_pkg::DET_W-1:0] detents_r;
  logic [odqd_pkg::DIR_W-1:0] dir_r;
  logic [odqd_pkg::DET_W-1:0] detents_eff;
  logic                       cfg_wr;

  // stream decode
  logic                        accept;
  logic                        rd_fire;
  logic [odqd_pkg::CH_W-1:0]   rd_channel;
  odqd_pkg::lane_ctrl_t        lane_ctrl;
  logic                        buf_full;
  odqd_pkg::result_t           rd_result;
  odqd_pkg::result_t           out_result;

  logic signed [odqd_pkg::DELTA_W-1:0] lane_count [ENCODER_COUNT];
  logic signed [odqd_pkg::DELTA_W-1:0] rd_delta;

  // --- APB registers ---
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      detents_r <= odqd_pkg::DETENTS_RESET;
      dir_r     <= '0;
    end else if (cfg_wr) begin
      if (cfg_paddr[2] == odqd_pkg::REG_DETENTS) begin
        detents_r <= cfg_pwdata[odqd_pkg::DET_W-1:0];
      end else begin
        dir_r <= cfg_pwdata[odqd_pkg::DIR_W-1:0];
      end
    end
  end

  always_comb begin
    if (cfg_paddr[2] == odqd_pkg::REG_DIRECTION) begin
      cfg_prdata = {24'd0, dir_r};
    end else begin
      cfg_prdata = {29'd0, detents_r};
    end
  end

  // out-of-range settings clamp to 1..4
  always_comb begin
    if (detents_r < odqd_pkg::DETENTS_MIN) begin
      detents_eff = odqd_pkg::DETENTS_MIN;
    end else if (detents_r > odqd_pkg::DETENTS_MAX) begin
      detents_eff = odqd_pkg::DETENTS_MAX;
    end else begin
      detents_eff = detents_r;
    end
  end

  // --- command decode ---
  assign in_tready  = !buf_full;
  assign accept     = in_tvalid && in_tready;
  assign rd_channel = in_tdata[18:16];
  assign rd_fire    = accept && (in_tuser == odqd_pkg::CMD_READ);

  always_comb begin
    lane_ctrl.count_en = accept && (in_tuser == odqd_pkg::CMD_COUNT);
    lane_ctrl.seed_en  = accept && (in_tuser == odqd_pkg::CMD_SEED);
    lane_ctrl.detents  = detents_eff;
  end

  // --- encoder lanes; A on bit 2k, B on bit 2k+1, pair = {A, B} ---
  for (genvar k = 0; k < ENCODER_COUNT; k++) begin : g_lane
    odqd_lane u_lane (
      .clk      (clk),
      .rst_n    (rst_n),
      .ctrl     (lane_ctrl),
      .reverse  (dir_r[k]),
      .clear    (rd_fire && (rd_channel == odqd_pkg::CH_W'(k))),
      .cur_pair ({in_tdata[2*k], in_tdata[2*k+1]}),
      .count    (lane_count[k])
    );
  end

  // --- merge: pick the read channel; channels past ENCODER_COUNT read zero ---
  always_comb begin
    rd_delta = '0;
    for (int k = 0; k < ENCODER_COUNT; k++) begin
      if (rd_channel == odqd_pkg::CH_W'(k)) begin
        rd_delta = lane_count[k];
      end
    end
    rd_result.channel = rd_channel;
    rd_result.delta   = rd_delta;
  end

  odqd_outbuf u_outbuf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (rd_fire),
    .push_data (rd_result),
    .full      (buf_full),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_data  (out_result)
  );

  assign out_tdata = {5'd0, out_result};

endmodule

@@ design/odqd_lane.sv @@
// ----------------------------------------------------------------------------
// odqd_lane
// One encoder channel: previous pair, step accumulator, saturating count.
// ----------------------------------------------------------------------------
module odqd_lane (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  odqd_pkg::lane_ctrl_t                 ctrl,
  input  logic                                 reverse,
  input  logic                                 clear,
  input  logic [1:0]                           cur_pair,
  output logic signed [odqd_pkg::DELTA_W-1:0]  count
);

  logic [1:0]                           prev_r, prev_nxt;
  logic signed [odqd_pkg::ACC_W-1:0]    acc_r, acc_nxt;
  logic signed [odqd_pkg::DELTA_W-1:0]  count_r, count_nxt;
  logic signed [1:0]                    step;
  logic signed [odqd_pkg::ACC_W:0]      acc_sum, acc_red, det_s;
  logic                                 fwd, back, inc, dec;

  always_comb begin
    step    = odqd_pkg::step_of({prev_r, cur_pair});
    acc_sum = {acc_r[odqd_pkg::ACC_W-1], acc_r}
            + {{(odqd_pkg::ACC_W-1){step[1]}}, step};
    det_s   = signed'({2'b00, ctrl.detents});
    prev_nxt  = prev_r;
    acc_nxt   = acc_r;
    count_nxt = count_r;
    acc_red   = acc_sum;
    fwd       = 1'b0;
    back      = 1'b0;
    if (ctrl.count_en) begin
      prev_nxt = cur_pair;
      if (step != 2'sd0) begin
        if (acc_sum >= det_s) begin
          fwd     = 1'b1;
          acc_red = acc_sum - det_s;
        end else if (acc_sum <= -det_s) begin
          back    = 1'b1;
          acc_red = acc_sum + det_s;
        end
        acc_nxt = acc_red[odqd_pkg::ACC_W-1:0];
      end
    end
    if (ctrl.seed_en) begin
      prev_nxt = cur_pair;
    end
    inc = (fwd && !reverse) || (back && reverse);
    dec = (fwd && reverse) || (back && !reverse);
    // saturate at the int8 limits
    if (inc && count_r != 8'sd127) begin
      count_nxt = count_r + 8'sd1;
    end else if (dec && count_r != -8'sd128) begin
      count_nxt = count_r - 8'sd1;
    end
    if (clear) begin
      count_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r  <= '0;
      acc_r   <= '0;
      count_r <= '0;
    end else begin
      prev_r  <= prev_nxt;
      acc_r   <= acc_nxt;
      count_r <= count_nxt;
    end
  end

  assign count = count_r;

endmodule

@@ design/odqd_outbuf.sv @@
// ----------------------------------------------------------------------------
// odqd_outbuf
// Result register with a skid stage so the input side keeps moving while a
// result waits on the receiver.
// ----------------------------------------------------------------------------
module odqd_outbuf (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  odqd_pkg::result_t push_data,
  output logic              full,
  output logic              out_valid,
  input  logic              out_ready,
  output odqd_pkg::result_t out_data
);

  logic              out_valid_r, out_valid_nxt;
  logic              skid_valid_r, skid_valid_nxt;
  odqd_pkg::result_t out_data_r, out_data_nxt;
  odqd_pkg::result_t skid_data_r, skid_data_nxt;

  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_data_nxt   = out_data_r;
    skid_valid_nxt = skid_valid_r;
    skid_data_nxt  = skid_data_r;
    if (!out_valid_r || out_ready) begin
      if (skid_valid_r) begin
        out_valid_nxt  = 1'b1;
        out_data_nxt   = skid_data_r;
        skid_valid_nxt = 1'b0;
      end else begin
        out_valid_nxt = push;
        if (push) begin
          out_data_nxt = push_data;
        end
      end
    end else if (push) begin
      skid_valid_nxt = 1'b1;
      skid_data_nxt  = push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
    out_data_r  <= out_data_nxt;
    skid_data_r <= skid_data_nxt;
  end

  assign full      = skid_valid_r;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef SYNTH
  a_skid_implies_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid holds a result while output is empty");

  a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !skid_valid_r)
    else $error("result pushed into a full buffer");

  a_stall_fills_skid: assert property (@(posedge clk) disable iff (!rst_n)
    (push && out_valid_r && !out_ready) |=> skid_valid_r)
    else $error("stalled result not caught by skid stage");

  a_skid_drains: assert property (@(posedge clk) disable iff (!rst_n)
    (skid_valid_r && out_ready) |=> (out_valid_r && !skid_valid_r))
    else $error("skid stage failed to drain");
`endif

endmodule
